// File: rtl/number_to_chinese_reading_tokens_top_defines.svh
// assertion macros for the chinese number reading block
// used by the port checker; needs nothing else
`ifndef NUMBER_TO_CHINESE_READING_TOKENS_TOP_DEFINES_SVH
`define NUMBER_TO_CHINESE_READING_TOKENS_TOP_DEFINES_SVH

// same-cycle implication
`define NCR_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ncr assertion failed");

// next-cycle implication
`define NCR_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ncr assertion failed");

// implication after a fixed delay
`define NCR_ASSERT_DLY(name, clk, rst_n, ante, n, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
    else $error("ncr assertion failed");

`endif

// File: rtl/ncr_pkg.sv
// shared types, token codes and the bcd adjust-and-shift step
// no dependencies
`timescale 1ns / 1ps

package ncr_pkg;

  localparam int VALUE_W    = 31;
  localparam int TOKEN_W    = 4;
  localparam int MAG_W      = 30;
  localparam int DIG_W      = 4;
  localparam int NUM_DIGITS = 9;
  localparam int POS_W      = 4;
  localparam int GROUP      = 4;

  localparam logic [MAG_W-1:0] MAX_MAG = 30'd999999999;

  localparam logic [TOKEN_W-1:0] TOK_LING = 4'd0;
  localparam logic [TOKEN_W-1:0] TOK_SHI  = 4'd10;
  localparam logic [TOKEN_W-1:0] TOK_WAN  = 4'd13;
  localparam logic [TOKEN_W-1:0] TOK_YI   = 4'd14;
  localparam logic [TOKEN_W-1:0] TOK_FU   = 4'd15;

  typedef logic [NUM_DIGITS-1:0][DIG_W-1:0] bcd_t;

  typedef struct packed {
    logic start;
    logic neg;
  } emit_req_t;

  // one double-dabble bit: add three to digits of five and up, then shift in
  function automatic bcd_t dabble(input bcd_t b, input logic bin_bit);
    bcd_t                          adj;
    logic [NUM_DIGITS*DIG_W:0]     wide;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      adj[i] = (b[i] >= 4'd5) ? (b[i] + 4'd3) : b[i];
    end
    wide = {adj, bin_bit};
    return wide[NUM_DIGITS*DIG_W-1:0];
  endfunction

endpackage

// File: rtl/ncr_if.sv
// request channels of the chinese number reading block
// depends on ncr_pkg
`timescale 1ns / 1ps

interface ncr_in_if;
  import ncr_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;
  modport source (output valid, value, input ready);
  modport sink   (input valid, value, output ready);
endinterface

interface ncr_out_if;
  import ncr_pkg::*;
  logic               valid;
  logic               ready;
  logic [TOKEN_W-1:0] token;
  logic               last;
  modport source (output valid, token, last, input ready);
  modport sink   (input valid, token, last, output ready);
endinterface

// File: rtl/ncr_bcd.sv
// iterative binary to bcd converter, two bits per cycle through two chained adjust steps
// depends on ncr_pkg
`timescale 1ns / 1ps

module ncr_bcd (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start_i,
  input  logic [ncr_pkg::MAG_W-1:0] mag_i,
  output logic                      busy_o,
  output ncr_pkg::bcd_t             digits_o
);
  import ncr_pkg::*;

  localparam int STEPS = MAG_W / 2;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic             busy_r, busy_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [MAG_W-1:0] bin_r, bin_nxt;
  bcd_t             bcd_r, bcd_nxt;
  bcd_t             step1;

  always_comb begin
    step1    = dabble(bcd_r, bin_r[MAG_W-1]);
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    bin_nxt  = bin_r;
    bcd_nxt  = bcd_r;
    if (start_i) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(STEPS);
      bin_nxt  = mag_i;
      bcd_nxt  = '0;
    end else if (busy_r) begin
      bcd_nxt = dabble(step1, bin_r[MAG_W-2]);
      bin_nxt = {bin_r[MAG_W-3:0], 2'b00};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
  end

  assign busy_o   = busy_r;
  assign digits_o = bcd_r;

endmodule

// File: rtl/ncr_emit.sv
// token sequencer: walks the nine digits from the top and feeds the output register
// depends on ncr_pkg
`timescale 1ns / 1ps

module ncr_emit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ncr_pkg::emit_req_t          req_i,
  input  ncr_pkg::bcd_t               digits_i,
  output logic                        busy_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [ncr_pkg::TOKEN_W-1:0] out_token_o,
  output logic                        out_last_o
);
  import ncr_pkg::*;

  typedef enum logic [2:0] {
    E_IDLE = 3'b001,
    E_FU   = 3'b010,
    E_DIG  = 3'b100
  } estate_t;

  localparam logic [POS_W-1:0] POS_TOP = POS_W'(NUM_DIGITS - 1);
  localparam logic [POS_W-1:0] POS_WAN = POS_W'(GROUP);

  estate_t            state_r, state_nxt;
  logic [POS_W-1:0]   p_r, p_nxt;
  logic [3:0]         done_r, done_nxt;
  logic               pending_r, pending_nxt;
  logic               higher_r, higher_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [TOKEN_W-1:0] out_token_r, out_token_nxt;
  logic               out_last_r, out_last_nxt;

  logic [NUM_DIGITS-1:0] nzv;
  logic [NUM_DIGITS-1:0] lowmask;
  logic [DIG_W-1:0]      dig;
  logic [1:0]            place;
  logic                  d_nz, lower_zero, slot_free;
  logic                  wan_owed;
  logic [3:0]            mask, need, sel, rest;
  logic [TOKEN_W-1:0]    tok;
  logic                  adv_pending, adv_higher;

  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      nzv[i] = (digits_i[i] != '0);
    end
    dig        = digits_i[p_r];
    place      = p_r[1:0];
    d_nz       = (dig != '0);
    lowmask    = (NUM_DIGITS'(1) << p_r) - NUM_DIGITS'(1);
    // a token in the upper digits of the wan group still owes the wan word
    wan_owed   = (p_r > POS_WAN) && (p_r < POS_TOP);
    lower_zero = ((nzv & lowmask) == '0) && !wan_owed;
    // ling, digit, unit word, group word
    mask[0] = d_nz && pending_r;
    mask[1] = d_nz;
    mask[2] = d_nz && (place != 2'b00);
    mask[3] = ((p_r == POS_TOP) && d_nz) ||
              ((p_r == POS_WAN) && (|nzv[2*GROUP-1:GROUP]));
    need = mask & ~done_r;
    sel  = need & (~need + 4'd1);
    rest = need & ~sel;
    if (need[0]) begin
      tok = TOK_LING;
    end else if (need[1]) begin
      tok = dig;
    end else if (need[2]) begin
      tok = TOK_SHI - 4'd1 + {2'b00, place};
    end else if (p_r == POS_TOP) begin
      tok = TOK_YI;
    end else begin
      tok = TOK_WAN;
    end
    // zero runs arm a ling only below a nonzero digit and not at a group's units
    adv_pending = d_nz ? 1'b0 : (((place != 2'b00) && higher_r) ? 1'b1 : pending_r);
    adv_higher  = higher_r | d_nz;
  end

  assign slot_free = !out_valid_r || out_ready_i;

  always_comb begin
    state_nxt     = state_r;
    p_nxt         = p_r;
    done_nxt      = done_r;
    pending_nxt   = pending_r;
    higher_nxt    = higher_r;
    out_valid_nxt = out_ready_i ? 1'b0 : out_valid_r;
    out_token_nxt = out_token_r;
    out_last_nxt  = out_last_r;
    case (state_r)
      E_IDLE: begin
        if (req_i.start) begin
          p_nxt       = POS_TOP;
          done_nxt    = '0;
          pending_nxt = 1'b0;
          higher_nxt  = 1'b0;
          state_nxt   = req_i.neg ? E_FU : E_DIG;
        end
      end
      E_FU: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_token_nxt = TOK_FU;
          out_last_nxt  = 1'b0;
          state_nxt     = E_DIG;
        end
      end
      E_DIG: begin
        if (nzv == '0) begin
          // zero reads as a lone ling
          if (slot_free) begin
            out_valid_nxt = 1'b1;
            out_token_nxt = TOK_LING;
            out_last_nxt  = 1'b1;
            state_nxt     = E_IDLE;
          end
        end else if (need == '0) begin
          pending_nxt = adv_pending;
          higher_nxt  = adv_higher;
          done_nxt    = '0;
          p_nxt       = p_r - POS_W'(1);
          if (p_r == '0) begin
            state_nxt = E_IDLE;
          end
        end else if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_token_nxt = tok;
          out_last_nxt  = (rest == '0) && lower_zero;
          if (rest == '0) begin
            pending_nxt = adv_pending;
            higher_nxt  = adv_higher;
            done_nxt    = '0;
            p_nxt       = p_r - POS_W'(1);
            if (lower_zero || (p_r == '0)) begin
              state_nxt = E_IDLE;
            end
          end else begin
            done_nxt = done_r | sel;
          end
        end
      end
      default: state_nxt = E_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= E_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r         <= p_nxt;
    done_r      <= done_nxt;
    pending_r   <= pending_nxt;
    higher_r    <= higher_nxt;
    out_token_r <= out_token_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign busy_o      = (state_r != E_IDLE);
  assign out_valid_o = out_valid_r;
  assign out_token_o = out_token_r;
  assign out_last_o  = out_last_r;

endmodule

// File: rtl/number_to_chinese_reading_tokens_top.sv
// Chinese number reading: one signed request in, a run of word tokens out. A request
// carries a 31-bit two's complement value; magnitudes above 999999999 saturate to that,
// sign kept. The reading comes out one token per result request, fu first for negative
// values, digits read in yi, wan and unit groups with shi/bai/qian after each nonzero
// digit above a group's units, a single ling where skipped zeros sit under a higher nonzero
// digit, and the final token flagged by last. One request is worked at a time: in_ready is
// high only while the block is idle. The magnitude is registered, converted to bcd two bits
// a cycle through two chained adjust steps, then read out by a sequencer that emits at most
// one token a cycle and stalls while back pressure holds the output register. The next
// request is taken while the last token still waits in the output register.
// depends on ncr_pkg, ncr_if, ncr_bcd and ncr_emit
`timescale 1ns / 1ps

module number_to_chinese_reading_tokens_top (
  input logic        clk,
  input logic        rst_n,
  ncr_in_if.sink     in_ch,
  ncr_out_if.source  out_ch
);
  import ncr_pkg::*;

  typedef enum logic [3:0] {
    T_IDLE = 4'b0001,
    T_LOAD = 4'b0010,
    T_CONV = 4'b0100,
    T_EMIT = 4'b1000
  } tstate_t;

  tstate_t          state_r, state_nxt;
  logic             neg_r, neg_nxt;
  logic [MAG_W-1:0] mag_r, mag_nxt;

  logic             accept;
  logic             raw_neg;
  logic [VALUE_W-1:0] raw_u, mag_full;
  logic             bcd_start, bcd_busy, emit_busy;
  bcd_t             digits;
  emit_req_t        emit_req;

  assign in_ch.ready = (state_r == T_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;

  // magnitude and saturation, registered before conversion starts
  always_comb begin
    raw_u    = $unsigned(in_ch.value);
    raw_neg  = raw_u[VALUE_W-1];
    mag_full = raw_neg ? (VALUE_W'(0) - raw_u) : raw_u;
    neg_nxt  = neg_r;
    mag_nxt  = mag_r;
    if (accept) begin
      neg_nxt = raw_neg;
      mag_nxt = (mag_full > {1'b0, MAX_MAG}) ? MAX_MAG : mag_full[MAG_W-1:0];
    end
  end

  // request sequencer
  always_comb begin
    state_nxt      = state_r;
    bcd_start      = 1'b0;
    emit_req.start = 1'b0;
    emit_req.neg   = neg_r;
    case (state_r)
      T_IDLE: begin
        if (accept) begin
          state_nxt = T_LOAD;
        end
      end
      T_LOAD: begin
        bcd_start = 1'b1;
        state_nxt = T_CONV;
      end
      T_CONV: begin
        if (!bcd_busy) begin
          emit_req.start = 1'b1;
          state_nxt      = T_EMIT;
        end
      end
      T_EMIT: begin
        if (!emit_busy) begin
          state_nxt = T_IDLE;
        end
      end
      default: state_nxt = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= T_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r <= neg_nxt;
    mag_r <= mag_nxt;
  end

  ncr_bcd u_bcd (
    .clk      (clk),
    .rst_n    (rst_n),
    .start_i  (bcd_start),
    .mag_i    (mag_r),
    .busy_o   (bcd_busy),
    .digits_o (digits)
  );

  ncr_emit u_emit (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_i       (emit_req),
    .digits_i    (digits),
    .busy_o      (emit_busy),
    .out_valid_o (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .out_token_o (out_ch.token),
    .out_last_o  (out_ch.last)
  );

endmodule

// File: rtl/ncr_checker.sv
// port-level checker for the chinese number reading block, bound to the top level
// depends on ncr_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "number_to_chinese_reading_tokens_top_defines.svh"

module ncr_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [ncr_pkg::TOKEN_W-1:0] out_token,
  input logic                        out_last
);
  import ncr_pkg::*;

  // a stalled token holds
  `NCR_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_token) && $stable(out_last))

  // one request at a time
  `NCR_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)

  // conversion keeps the block busy well past the accept
  `NCR_ASSERT_DLY(a_conv_busy, clk, rst_n, in_valid && in_ready, 17, !in_ready)

  // fu always leads into digits
  `NCR_ASSERT_IMP(a_fu_not_last, clk, rst_n, out_valid && (out_token == TOK_FU), !out_last)

endmodule

bind number_to_chinese_reading_tokens_top ncr_checker u_ncr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_token (out_ch.token),
  .out_last  (out_ch.last)
);

// File: tb/tb_number_to_chinese_reading_tokens_top.sv
// self-checking testbench for the chinese number reading block
// drives signed numbers, predicts each token run and compares it token by token
// depends on ncr_pkg, ncr_if and number_to_chinese_reading_tokens_top
`timescale 1ns / 1ps

module tb_number_to_chinese_reading_tokens_top;
  import ncr_pkg::*;

  // one word of the spoken reading as it leaves the block
  typedef struct packed {
    logic [TOKEN_W-1:0] token;
    logic               last;
  } reading_tok_t;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 60;
  localparam int RANDOM_COUNT = 410;
  localparam int HOLD_AT      = 150;  // request count that starts the long output hold
  localparam int HOLD_CYCLES  = 400;
  localparam int CALM_FROM    = 260;  // window with no idling on either side
  localparam int CALM_TO      = 330;

  logic clk = 1'b0;
  logic rst_n;

  ncr_in_if  in_if ();
  ncr_out_if out_if ();

  number_to_chinese_reading_tokens_top DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // numbers waiting to be offered, and the token runs the block still owes us
  logic signed [VALUE_W-1:0] numbers_to_send[$];
  reading_tok_t              reading_q[$];

  int numbers_sent;
  int tokens_seen;
  int mismatches;
  int cycle_cnt;
  int send_gap;
  int recv_stall;
  int hold_cnt;
  bit hold_done;

  // ---------------------------------------------------------------------------
  // predictor: spoken reading of one number, appended to reading_q
  // ---------------------------------------------------------------------------
  function automatic void read_aloud(input logic signed [VALUE_W-1:0] num);
    logic [31:0]        mag;
    logic [3:0]         digit[NUM_DIGITS];
    logic [TOKEN_W-1:0] words[$];
    bit                 neg;
    bit                 ling_owed;
    bit                 seen_nonzero;
    int                 place;
    reading_tok_t       t;

    neg = num[VALUE_W-1];
    // magnitude of the two's complement value; the most negative one gives 2^30
    mag = neg ? (32'h8000_0000 - {1'b0, num}) : {1'b0, num};
    if (mag > 32'd999999999) mag = 32'd999999999;

    if (mag == 0) begin
      words.push_back(TOK_LING);
    end else begin
      for (int p = 0; p < NUM_DIGITS; p++) begin
        digit[p] = 4'(mag % 10);
        mag      = mag / 10;
      end
      if (neg) words.push_back(TOK_FU);
      ling_owed    = 1'b0;
      seen_nonzero = 1'b0;
      for (int p = NUM_DIGITS - 1; p >= 0; p--) begin
        place = p % GROUP;
        if (digit[p] != 0) begin
          // skipped zeros under a higher digit collapse into one ling,
          // which may carry across a group boundary
          if (ling_owed) begin
            words.push_back(TOK_LING);
            ling_owed = 1'b0;
          end
          words.push_back(digit[p]);
          if (place != 0) words.push_back(TOK_SHI + TOKEN_W'(place - 1));
          seen_nonzero = 1'b1;
        end else if (place != 0 && seen_nonzero) begin
          ling_owed = 1'b1;
        end
        // group words only after a nonzero group
        if (p == 2 * GROUP && digit[8] != 0) words.push_back(TOK_YI);
        if (p == GROUP && (digit[4] | digit[5] | digit[6] | digit[7]) != 0)
          words.push_back(TOK_WAN);
      end
    end

    foreach (words[i]) begin
      t.token = words[i];
      t.last  = (i == words.size() - 1);
      reading_q.push_back(t);
    end
  endfunction

  // random number: mostly sparse digit patterns, some uniform, some raw 31-bit
  function automatic logic signed [VALUE_W-1:0] pick_number();
    int n;
    int kind;
    int top;
    kind = $urandom_range(0, 9);
    if (kind < 6) begin
      // zeros are common so ling and group-word rules get exercised
      top = $urandom_range(0, 8);
      n   = 0;
      for (int p = top; p >= 0; p--) begin
        n = n * 10;
        if ($urandom_range(0, 1)) n += $urandom_range(1, 9);
      end
    end else if (kind < 8) begin
      n = $urandom_range(0, 999999999);
    end else begin
      // full 31-bit field, out-of-range magnitudes included
      return VALUE_W'($urandom());
    end
    if ($urandom_range(0, 1)) n = -n;
    return VALUE_W'(n);
  endfunction

  // per-request idle draw, none inside the calm window
  function automatic int idle_draw();
    if (numbers_sent >= CALM_FROM && numbers_sent < CALM_TO) return 0;
    return $urandom_range(0, 11);
  endfunction

  // ---------------------------------------------------------------------------
  // driver: offers queued numbers, predicts each one when it is taken
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid  <= 1'b0;
      in_if.value  <= '0;
      send_gap     <= 0;
      numbers_sent <= 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        read_aloud(in_if.value);
        numbers_sent <= numbers_sent + 1;
      end
      if (in_if.valid && !in_if.ready) begin
        // request still waiting: hold it steady
      end else if (send_gap != 0) begin
        send_gap    <= send_gap - 1;
        in_if.valid <= 1'b0;
      end else if (numbers_to_send.size() != 0) begin
        in_if.valid <= 1'b1;
        in_if.value <= numbers_to_send.pop_front();
        send_gap    <= idle_draw();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // long receiver hold once, so the block fills up and stalls its input
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_cnt  <= 0;
      hold_done <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end else if (!hold_done && numbers_sent >= HOLD_AT) begin
      hold_cnt  <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks every token against the oldest prediction, random stalls
  // ---------------------------------------------------------------------------
  int           next_stall;
  reading_tok_t got_tok;
  reading_tok_t exp_tok;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      recv_stall   <= 0;
      tokens_seen  <= 0;
      mismatches   <= 0;
    end else begin
      next_stall = recv_stall;
      if (out_if.valid && out_if.ready) begin
        got_tok.token = out_if.token;
        got_tok.last  = out_if.last;
        tokens_seen  <= tokens_seen + 1;
        if (reading_q.size() == 0) begin
          if (mismatches < 10)
            $display("token %0d: unexpected token=%0d last=%0b", tokens_seen,
                     got_tok.token, got_tok.last);
          mismatches <= mismatches + 1;
        end else begin
          exp_tok = reading_q.pop_front();
          if (got_tok.token !== exp_tok.token || got_tok.last !== exp_tok.last) begin
            if (mismatches < 10)
              $display("token %0d: expected token=%0d last=%0b, got token=%0d last=%0b",
                       tokens_seen, exp_tok.token, exp_tok.last,
                       got_tok.token, got_tok.last);
            mismatches <= mismatches + 1;
          end
        end
        next_stall = idle_draw();
      end
      if (hold_cnt != 0) begin
        out_if.ready <= 1'b0;
        recv_stall   <= next_stall;
      end else if (next_stall != 0) begin
        out_if.ready <= 1'b0;
        recv_stall   <= next_stall - 1;
      end else begin
        out_if.ready <= 1'b1;
        recv_stall   <= 0;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------
  int directed_values[] = '{
    0, 1, -1, 10, 100, 110, 1001, 1010, 20000, 100000,
    100000000,       // yi group alone
    100000001,       // ling after an empty wan group
    10000001,        // ling carried across the wan boundary
    100010000, 101010101, 123456789,
    999999999, -999999999,
    -1000000000,     // magnitude above nine digits saturates
    1073741823,      // largest positive field value
    -1073741824,     // most negative field value
    -20304050
  };

  initial begin
    cycle_cnt     = 0;
    rst_n         = 1'b0;
    in_if.valid   = 1'b0;
    in_if.value   = '0;
    out_if.ready  = 1'b0;

    foreach (directed_values[i]) numbers_to_send.push_back(VALUE_W'(directed_values[i]));
    repeat (RANDOM_COUNT) numbers_to_send.push_back(pick_number());

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // everything offered and taken, every predicted token seen
    while (numbers_to_send.size() != 0 || in_if.valid || reading_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && reading_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/ncr_pkg.sv
rtl/ncr_if.sv
rtl/ncr_bcd.sv
rtl/ncr_emit.sv
rtl/number_to_chinese_reading_tokens_top.sv
rtl/ncr_checker.sv
tb/tb_number_to_chinese_reading_tokens_top.sv
